@@ rtl/qrs_pkg.sv @@
package qrs_pkg;

	localparam logic [1:0] ST_REAL  = 2'd0;
	localparam logic [1:0] ST_CPLX  = 2'd1;
	localparam logic [1:0] ST_AZERO = 2'd2;
	localparam logic [1:0] ST_SAT   = 2'd3;

	localparam int FIFO_AW    = 3;
	localparam int FIFO_DEPTH = 1 << FIFO_AW;

	// classification of one item, carried from the front to the back
	typedef struct packed {
		logic a_zero;
		logic a_neg;
		logic b_neg;
		logic d_neg;
	} qrs_flags_t;

endpackage

@@ rtl/qrs_if.sv @@
interface qrs_coef_if #(parameter int WORD_BITS = 32) ();
	logic                        valid;
	logic                        ready;
	logic signed [WORD_BITS-1:0] coef_a;
	logic signed [WORD_BITS-1:0] coef_b;
	logic signed [WORD_BITS-1:0] coef_c;

	modport source (output valid, coef_a, coef_b, coef_c, input ready);
	modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_root_if #(parameter int WORD_BITS = 32) ();
	logic                        valid;
	logic                        ready;
	logic signed [WORD_BITS-1:0] root1_real;
	logic signed [WORD_BITS-1:0] root1_imag;
	logic signed [WORD_BITS-1:0] root2_real;
	logic signed [WORD_BITS-1:0] root2_imag;
	logic [1:0]                  status;

	modport source (output valid, root1_real, root1_imag, root2_real, root2_imag, status,
		input ready);
	modport sink   (input valid, root1_real, root1_imag, root2_real, root2_imag, status,
		output ready);
endinterface

@@ rtl/qrs_front.sv @@
module qrs_front
	import qrs_pkg::*;
#(
	parameter int WORD_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	qrs_coef_if.sink                  coef,
	input  logic [FIFO_AW:0]          fifo_cnt,
	output logic                      push,
	output qrs_flags_t                push_flags,
	output logic [WORD_BITS-1:0]      push_ma,
	output logic [WORD_BITS-1:0]      push_mb,
	output logic [2*WORD_BITS+1:0]    push_dmag
);
	localparam int W  = WORD_BITS;
	localparam int RB = 2 * W + 2;

	logic [W-1:0]   a_mag, b_mag, c_mag;
	logic           v_s1, v_s2, v_s3;
	qrs_flags_t     fl_s1, fl_s2, fl_s3;
	logic           c_neg_s1;
	logic [W-1:0]   ma_s1, mb_s1, mc_s1, ma_s2, mb_s2, ma_s3, mb_s3;
	logic [2*W-1:0] bb_s2, ac_s2;
	logic           sub_s2;
	logic [RB:0]    bbx, ac4, dsum;
	logic [RB-1:0]  dmag_s3;
	logic [FIFO_AW+1:0] used;
	logic           take;

	assign a_mag = coef.coef_a[W-1] ? (~coef.coef_a + 1'b1) : coef.coef_a;
	assign b_mag = coef.coef_b[W-1] ? (~coef.coef_b + 1'b1) : coef.coef_b;
	assign c_mag = coef.coef_c[W-1] ? (~coef.coef_c + 1'b1) : coef.coef_c;

	// credit: everything in flight must find room in the queue
	assign used = {1'b0, fifo_cnt} + (FIFO_AW+2)'(v_s1) + (FIFO_AW+2)'(v_s2)
		+ (FIFO_AW+2)'(v_s3);
	assign coef.ready = used < (FIFO_AW+2)'(FIFO_DEPTH);
	assign take = coef.valid && coef.ready;

	assign bbx  = {3'b000, bb_s2};
	assign ac4  = {1'b0, ac_s2, 2'b00};
	assign dsum = sub_s2 ? (bbx - ac4) : (bbx + ac4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		fl_s1.a_zero <= (a_mag == '0);
		fl_s1.a_neg  <= coef.coef_a[W-1];
		fl_s1.b_neg  <= coef.coef_b[W-1];
		fl_s1.d_neg  <= 1'b0;
		c_neg_s1     <= coef.coef_c[W-1];
		ma_s1        <= a_mag;
		mb_s1        <= b_mag;
		mc_s1        <= c_mag;

		fl_s2  <= fl_s1;
		ma_s2  <= ma_s1;
		mb_s2  <= mb_s1;
		bb_s2  <= mb_s1 * mb_s1;
		ac_s2  <= ma_s1 * mc_s1;
		sub_s2 <= (fl_s1.a_neg == c_neg_s1);

		fl_s3   <= {fl_s2.a_zero, fl_s2.a_neg, fl_s2.b_neg, dsum[RB]};
		ma_s3   <= ma_s2;
		mb_s3   <= mb_s2;
		dmag_s3 <= dsum[RB] ? RB'(~dsum + 1'b1) : dsum[RB-1:0];
	end

	assign push       = v_s3;
	assign push_flags = fl_s3;
	assign push_ma    = ma_s3;
	assign push_mb    = mb_s3;
	assign push_dmag  = dmag_s3;
endmodule

@@ rtl/qrs_fifo.sv @@
module qrs_fifo
	import qrs_pkg::*;
#(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty,
	output logic [FIFO_AW:0] cnt
);
	logic [WIDTH-1:0]   mem [0:FIFO_DEPTH-1];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_AW:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign cnt   = cnt_q;
	assign dout  = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= din;
	end
endmodule

@@ rtl/qrs_back.sv @@
module qrs_back
	import qrs_pkg::*;
#(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   empty,
	input  qrs_flags_t             hd_flags,
	input  logic [WORD_BITS-1:0]   hd_ma,
	input  logic [WORD_BITS-1:0]   hd_mb,
	input  logic [2*WORD_BITS+1:0] hd_dmag,
	output logic                   pop,
	qrs_root_if.source             root
);
	localparam int W  = WORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int RB = 2 * W + 2;
	localparam int NS = W + 1;
	localparam int NM = W + 1;
	localparam int NQ = NM + F;

	logic en;

	// square root: one result bit per stage
	logic [NS:0]   sv_s;
	qrs_flags_t    sf_s [0:NS];
	logic [W-1:0]  sa_s [0:NS];
	logic [W-1:0]  sb_s [0:NS];
	logic [RB-1:0] sx_s [0:NS];
	logic [RB-1:0] sr_s [0:NS];

	// division: one quotient bit per stage, two lanes
	logic [NQ:0]  dv_s;
	qrs_flags_t   df_s  [0:NQ];
	logic         dg1_s [0:NQ];
	logic         dg2_s [0:NQ];
	logic [W:0]   dd_s  [0:NQ];
	logic [NQ-1:0] dn1_s [0:NQ];
	logic [NQ-1:0] dn2_s [0:NQ];
	logic [NQ-1:0] dq1_s [0:NQ];
	logic [NQ-1:0] dq2_s [0:NQ];
	logic [W:0]   dr1_s [0:NQ];
	logic [W:0]   dr2_s [0:NQ];

	logic ov_q;

	assign en  = !ov_q || root.ready;
	assign pop = en && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_s <= '0;
			dv_s <= '0;
			ov_q <= 1'b0;
		end else if (en) begin
			sv_s <= {sv_s[NS-1:0], pop};
			dv_s <= {dv_s[NQ-1:0], sv_s[NS]};
			ov_q <= dv_s[NQ];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sf_s[0] <= hd_flags;
			sa_s[0] <= hd_ma;
			sb_s[0] <= hd_mb;
			sx_s[0] <= hd_dmag;
			sr_s[0] <= '0;
		end
	end

	for (genvar j = 0; j < NS; j++) begin : g_sqrt
		localparam logic [RB-1:0] ONE = RB'(1) << (RB - 2 - 2 * j);
		logic [RB-1:0] t;
		logic          ge;
		assign t  = sr_s[j] + ONE;
		assign ge = sx_s[j] >= t;
		always_ff @(posedge clk) begin
			if (en) begin
				sf_s[j+1] <= sf_s[j];
				sa_s[j+1] <= sa_s[j];
				sb_s[j+1] <= sb_s[j];
				sx_s[j+1] <= ge ? (sx_s[j] - t) : sx_s[j];
				sr_s[j+1] <= ge ? ((sr_s[j] >> 1) + ONE) : (sr_s[j] >> 1);
			end
		end
	end

	// numerators: -b +/- sqrt for real roots, |b| and sqrt for a complex pair
	logic [NM-1:0]   qv;
	logic signed [NM+1:0] vb, vq, s1, s2;
	logic [NM-1:0]   n1, n2;
	logic            g1, g2;
	logic [NM-1:0]   mb_ext;

	assign qv     = sr_s[NS][NM-1:0];
	assign mb_ext = NM'(sb_s[NS]);
	assign vq     = $signed({2'b00, qv});
	assign vb     = sf_s[NS].b_neg ? $signed({2'b00, mb_ext}) : -$signed({2'b00, mb_ext});
	assign s1     = vb + vq;
	assign s2     = vb - vq;

	always_comb begin
		if (sf_s[NS].d_neg) begin
			n1 = mb_ext;
			g1 = (!sf_s[NS].b_neg) != sf_s[NS].a_neg;
			n2 = qv;
			g2 = 1'b0;
		end else begin
			n1 = s1[NM+1] ? NM'(-s1) : s1[NM-1:0];
			g1 = s1[NM+1] != sf_s[NS].a_neg;
			n2 = s2[NM+1] ? NM'(-s2) : s2[NM-1:0];
			g2 = s2[NM+1] != sf_s[NS].a_neg;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			df_s[0]  <= sf_s[NS];
			dg1_s[0] <= g1;
			dg2_s[0] <= g2;
			dd_s[0]  <= {sa_s[NS], 1'b0};
			dn1_s[0] <= NQ'(n1) << F;
			dn2_s[0] <= NQ'(n2) << F;
			dq1_s[0] <= '0;
			dq2_s[0] <= '0;
			dr1_s[0] <= '0;
			dr2_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < NQ; k++) begin : g_div
		logic [W+1:0] t1, t2;
		logic         ge1, ge2;
		assign t1  = {dr1_s[k], dn1_s[k][NQ-1-k]};
		assign t2  = {dr2_s[k], dn2_s[k][NQ-1-k]};
		assign ge1 = t1 >= {1'b0, dd_s[k]};
		assign ge2 = t2 >= {1'b0, dd_s[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				df_s[k+1]  <= df_s[k];
				dg1_s[k+1] <= dg1_s[k];
				dg2_s[k+1] <= dg2_s[k];
				dd_s[k+1]  <= dd_s[k];
				dn1_s[k+1] <= dn1_s[k];
				dn2_s[k+1] <= dn2_s[k];
				dq1_s[k+1] <= {dq1_s[k][NQ-2:0], ge1};
				dq2_s[k+1] <= {dq2_s[k][NQ-2:0], ge2};
				dr1_s[k+1] <= ge1 ? (W+1)'(t1 - {1'b0, dd_s[k]}) : t1[W:0];
				dr2_s[k+1] <= ge2 ? (W+1)'(t2 - {1'b0, dd_s[k]}) : t2[W:0];
			end
		end
	end

	function automatic logic [W:0] clamp_word(input logic neg, input logic [NQ:0] m);
		logic [NQ:0]  lim;
		logic [NQ:0]  mc;
		logic         sat;
		logic [W-1:0] w;
		lim = neg ? ((NQ+1)'(1) << (W - 1)) : (((NQ+1)'(1) << (W - 1)) - 1'b1);
		sat = m > lim;
		mc  = sat ? lim : m;
		w   = neg ? (~mc[W-1:0] + 1'b1) : mc[W-1:0];
		return {sat, w};
	endfunction

	qrs_flags_t   ff;
	logic [NQ:0]  q1r, q2r;
	logic [W:0]   c1, c2;
	logic [W-1:0] r1re, r1im, r2re, r2im;
	logic [1:0]   st;

	assign ff  = df_s[NQ];
	// round half away from zero on the magnitude
	assign q1r = {1'b0, dq1_s[NQ]} + (NQ+1)'({dr1_s[NQ], 1'b0} >= {1'b0, dd_s[NQ]});
	assign q2r = {1'b0, dq2_s[NQ]} + (NQ+1)'({dr2_s[NQ], 1'b0} >= {1'b0, dd_s[NQ]});
	assign c1  = clamp_word(dg1_s[NQ], q1r);
	assign c2  = clamp_word(dg2_s[NQ], q2r);

	always_comb begin
		if (ff.a_zero) begin
			r1re = '0;
			r1im = '0;
			r2re = '0;
			r2im = '0;
			st   = ST_AZERO;
		end else if (ff.d_neg) begin
			r1re = c1[W-1:0];
			r2re = c1[W-1:0];
			r1im = c2[W-1:0];
			r2im = ~c2[W-1:0] + 1'b1;
			st   = (c1[W] || c2[W]) ? ST_SAT : ST_CPLX;
		end else begin
			r1re = c1[W-1:0];
			r2re = c2[W-1:0];
			r1im = '0;
			r2im = '0;
			st   = (c1[W] || c2[W]) ? ST_SAT : ST_REAL;
		end
	end

	logic [W-1:0] r1re_q, r1im_q, r2re_q, r2im_q;
	logic [1:0]   st_q;

	always_ff @(posedge clk) begin
		if (en) begin
			r1re_q <= r1re;
			r1im_q <= r1im;
			r2re_q <= r2re;
			r2im_q <= r2im;
			st_q   <= st;
		end
	end

	assign root.valid      = ov_q;
	assign root.root1_real = r1re_q;
	assign root.root1_imag = r1im_q;
	assign root.root2_real = r2re_q;
	assign root.root2_imag = r2im_q;
	assign root.status     = st_q;
endmodule

@@ rtl/quadratic_root_solver.sv @@
// Quadratic root solver: takes a, b, c (signed, FRAC_BITS fraction bits) and returns both
// roots, real or as a complex-conjugate pair, saturated to the word, with a status code
// (real, complex, a is zero, saturated). One item is accepted per cycle while coef.ready
// is high. The bit-per-stage square-root and divider pipelines in the back end set the
// latency. A credit check against an 8-entry queue between the multiply front end and
// that back end sets coef.ready, so a stalled result output stops input only once the
// queued items and those in flight in the front end fill the queue.
module quadratic_root_solver
	import qrs_pkg::*;
#(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	qrs_coef_if.sink   coef,
	qrs_root_if.source root
);
	localparam int W  = WORD_BITS;
	localparam int RB = 2 * W + 2;
	localparam int EW = $bits(qrs_flags_t) + 2 * W + RB;

	logic             push, pop, empty;
	qrs_flags_t       push_flags, hd_flags;
	logic [W-1:0]     push_ma, push_mb, hd_ma, hd_mb;
	logic [RB-1:0]    push_dmag, hd_dmag;
	logic [EW-1:0]    din, dout;
	logic [FIFO_AW:0] cnt;

	qrs_front #(.WORD_BITS(W)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.coef       (coef),
		.fifo_cnt   (cnt),
		.push       (push),
		.push_flags (push_flags),
		.push_ma    (push_ma),
		.push_mb    (push_mb),
		.push_dmag  (push_dmag)
	);

	assign din = {push_flags, push_ma, push_mb, push_dmag};
	assign {hd_flags, hd_ma, hd_mb, hd_dmag} = dout;

	qrs_fifo #(.WIDTH(EW)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (din),
		.pop    (pop),
		.dout   (dout),
		.empty  (empty),
		.cnt    (cnt)
	);

	qrs_back #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.hd_flags (hd_flags),
		.hd_ma    (hd_ma),
		.hd_mb    (hd_mb),
		.hd_dmag  (hd_dmag),
		.pop      (pop),
		.root     (root)
	);
endmodule

@@ rtl/qrs_checker.sv @@
module qrs_checker
	import qrs_pkg::*;
#(
	parameter int WORD_BITS = 32
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 valid,
	input logic                 ready,
	input logic [WORD_BITS-1:0] r1re,
	input logic [WORD_BITS-1:0] r1im,
	input logic [WORD_BITS-1:0] r2re,
	input logic [WORD_BITS-1:0] r2im,
	input logic [1:0]           status
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(r1re) && $stable(r2re) && $stable(status))
		else $error("stalled result changed");

	a_azero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && status == ST_AZERO |-> r1re == '0 && r1im == '0 && r2re == '0 && r2im == '0)
		else $error("a-zero result not all zero");

	a_real: assert property (@(posedge clk) disable iff (!arst_n)
		valid && status == ST_REAL |-> r1im == '0 && r2im == '0)
		else $error("real roots carry an imaginary part");

	a_cplx: assert property (@(posedge clk) disable iff (!arst_n)
		valid && status == ST_CPLX |-> r1re == r2re && r2im == (~r1im + 1'b1))
		else $error("complex pair not conjugate");
endmodule

bind quadratic_root_solver qrs_checker #(.WORD_BITS(WORD_BITS)) u_qrs_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.valid  (root.valid),
	.ready  (root.ready),
	.r1re   (root.root1_real),
	.r1im   (root.root1_imag),
	.r2re   (root.root2_real),
	.r2im   (root.root2_imag),
	.status (root.status)
);
